[hw/rtl/hcal_pkg.sv]
package hcal_pkg;

  localparam int WordW         = 64;
  localparam int CodeLenW      = 7;
  localparam int DataLenW      = 6;
  localparam int CheckW        = 3;
  localparam int SyndW         = 7;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 7;
  localparam int MaxCodeLenDef = 64;

  localparam logic [CodeLenW-1:0] CodeLenRst = 7'd7;
  localparam logic [DataLenW-1:0] DataLenRst = 6'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCodeLen = 1'b0,
    CfgDataLen = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  typedef struct packed {
    logic             op;
    logic [WordW-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0]  word_out;
    logic [CheckW-1:0] check_bits;
    logic [SyndW-1:0]  syndrome_value;
    logic              code_valid;
    logic              error_seen;
    logic              uncorrectable;
    logic              params_bad;
  } rsp_t;

  // after stage 1: word is the scattered data (encode) or masked code word (decode)
  typedef struct packed {
    logic                op;
    logic                bad;
    logic [CheckW-1:0]   check_bits;
    logic [CodeLenW-1:0] n;
    logic [WordW-1:0]    word;
  } prep_t;

  typedef struct packed {
    prep_t            prep;
    logic [SyndW-1:0] synd;
  } synd_t;

  // 1-based code position of data bit k
  function automatic int data_pos(int k);
    int p;
    p = 0;
    for (int j = 0; j < 8; j++) begin
      if (k + 1 + p >= (1 << p)) p++;
    end
    return k + 1 + p;
  endfunction

  // word bits whose position has syndrome bit j set
  function automatic logic [WordW-1:0] synd_mask(int j);
    logic [WordW-1:0] m;
    m = '0;
    for (int p = 1; p <= WordW; p++) begin
      if (((p >> j) & 1) == 1) m[p-1] = 1'b1;
    end
    return m;
  endfunction

endpackage

[hw/rtl/hcal_prep.sv]
module hcal_prep
  import hcal_pkg::*;
#(
  parameter int MaxCodeLen = MaxCodeLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  req_t                req_i,
  input  logic [CodeLenW-1:0] code_len_i,
  input  logic [DataLenW-1:0] data_len_i,
  output logic                valid_o,
  output prep_t               prep_o
);

  logic [CodeLenW-1:0] n;
  logic [WordW-1:0]    mask_m, mask_n, data_m, scat;
  logic signed [7:0]   r;
  logic                enc_ok;
  logic [CheckW-1:0]   cnt;
  prep_t               prep_d, prep_q;
  logic                valid_q;

  assign n = (code_len_i > CodeLenW'(MaxCodeLen)) ? CodeLenW'(MaxCodeLen) : code_len_i;

  assign mask_m = ~({WordW{1'b1}} << data_len_i);
  assign mask_n = ~({WordW{1'b1}} << n);
  assign data_m = req_i.word_in & mask_m;

  // fixed spread of data bits onto non-power-of-two positions
  always_comb begin
    scat = '0;
    for (int k = 0; k < WordW; k++) begin
      if (data_pos(k) <= WordW) scat[data_pos(k)-1] = data_m[k];
    end
  end

  assign r = $signed({1'b0, n}) - $signed({2'b00, data_len_i});

  always_comb begin
    if (r <= 8'sd0) begin
      enc_ok = 1'b0;
    end else if (r >= 8'sd7) begin
      enc_ok = 1'b1;
    end else begin
      enc_ok = (8'd1 << r[2:0]) >= ({1'b0, n} + 8'd1);
    end
  end

  // parity positions up to n
  always_comb begin
    cnt = '0;
    for (int j = 0; j < CodeLenW; j++) begin
      cnt = cnt + CheckW'(n >= CodeLenW'(1 << j));
    end
  end

  always_comb begin
    prep_d.op         = req_i.op;
    prep_d.n          = n;
    prep_d.check_bits = cnt;
    if (req_i.op == OpDecode) begin
      prep_d.bad  = (n == '0);
      prep_d.word = req_i.word_in & mask_n;
    end else begin
      prep_d.bad  = !enc_ok;
      prep_d.word = scat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) prep_q <= prep_d;
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

[hw/rtl/hcal_syndrome.sv]
module hcal_syndrome
  import hcal_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  prep_t prep_i,
  output logic  valid_o,
  output synd_t synd_o
);

  synd_t synd_d, synd_q;
  logic  valid_q;

  // each syndrome bit is the parity of its position group
  always_comb begin
    synd_d.prep = prep_i;
    for (int j = 0; j < SyndW; j++) begin
      synd_d.synd[j] = ^(prep_i.word & synd_mask(j));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) synd_q <= synd_d;
  end

  assign valid_o = valid_q;
  assign synd_o  = synd_q;

endmodule

[hw/rtl/hcal_finish.sv]
module hcal_finish
  import hcal_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  synd_t synd_i,
  output logic  valid_o,
  output rsp_t  rsp_o
);

  logic [WordW-1:0]    enc_word, corr, gath;
  logic [SyndW-1:0]    s;
  logic [CodeLenW-1:0] n;
  logic                s_in_range;
  rsp_t                rsp_d, rsp_q;
  logic                valid_q;

  assign s          = synd_i.synd;
  assign n          = synd_i.prep.n;
  assign s_in_range = (s != '0) && (s <= n);

  // fill parity positions up to n
  always_comb begin
    enc_word = synd_i.prep.word;
    for (int j = 0; j < SyndW; j++) begin
      if ((1 << j) <= WordW) begin
        if ((CodeLenW'(1 << j) <= n) && s[j]) enc_word[(1 << j)-1] = 1'b1;
      end
    end
  end

  always_comb begin
    corr = synd_i.prep.word;
    if (s_in_range) corr[6'(s - 7'd1)] = ~corr[6'(s - 7'd1)];
  end

  always_comb begin
    gath = '0;
    for (int k = 0; k < WordW; k++) begin
      if (data_pos(k) <= WordW) gath[k] = corr[data_pos(k)-1];
    end
  end

  always_comb begin
    rsp_d = '0;
    if (synd_i.prep.bad) begin
      rsp_d.params_bad = 1'b1;
    end else if (synd_i.prep.op == OpDecode) begin
      rsp_d.word_out       = gath;
      rsp_d.check_bits     = synd_i.prep.check_bits;
      rsp_d.syndrome_value = s;
      rsp_d.code_valid     = (s == '0);
      rsp_d.error_seen     = (s != '0);
      rsp_d.uncorrectable  = (s > n);
    end else begin
      rsp_d.word_out   = enc_word;
      rsp_d.check_bits = synd_i.prep.check_bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

[hw/rtl/hamming_codec_any_length.sv]
// Channel   Signals                                   Direction  Transfer
// request   start, busy, req_i                        in         start && !busy
// result    done_o, rsp_o                             out        done_o, one cycle
// config    cfg_valid_i, cfg_ready_o, cfg_idx_i/data  in         cfg_valid_i && cfg_ready_o
//
// Three register stages: prep (mask, scatter, bound check), syndrome
// (XOR trees), finish (parity fill or correct and gather).
// One request per cycle, as busy stays low; done_o rises once the request
// has passed the prep, syndrome and finish registers.
// Reset clears the stage valid bits and loads code_len=7, data_len=4.
// The receiver cannot stall, so busy stays low and nothing is held.
module hamming_codec_any_length
  import hcal_pkg::*;
#(
  parameter int MaxCodeLen = MaxCodeLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                done_o,
  output rsp_t                rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CodeLenW-1:0] code_len_q, code_len_d;
  logic [DataLenW-1:0] data_len_q, data_len_d;
  logic                acc;
  logic                v1, v2;
  prep_t               prep;
  synd_t               synd;

  // pipeline never backs up
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start && !busy;

  always_comb begin
    code_len_d = code_len_q;
    data_len_d = data_len_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgCodeLen: code_len_d = cfg_data_i[CodeLenW-1:0];
        CfgDataLen: data_len_d = cfg_data_i[DataLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_len_q <= CodeLenRst;
      data_len_q <= DataLenRst;
    end else begin
      code_len_q <= code_len_d;
      data_len_q <= data_len_d;
    end
  end

  // stage 1: saturate n, bound check, place data or mask code word
  hcal_prep #(
    .MaxCodeLen(MaxCodeLen)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (acc),
    .req_i     (req_i),
    .code_len_i(code_len_q),
    .data_len_i(data_len_q),
    .valid_o   (v1),
    .prep_o    (prep)
  );

  // stage 2: syndrome over positions 1..n
  hcal_syndrome u_synd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v1),
    .prep_i (prep),
    .valid_o(v2),
    .synd_o (synd)
  );

  // stage 3: result word and flags, registered onto the ports
  hcal_finish u_finish (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2),
    .synd_i (synd),
    .valid_o(done_o),
    .rsp_o  (rsp_o)
  );

endmodule
